@@ rtl/core/vsc_pkg.sv @@
// Shared types, codes and constants of the voxel shape classifier.
// Used by vsc_lin, vsc_mul, vsc_cmp and the top level of rtl/core; depends on nothing.
`default_nettype none
package vsc_pkg;

  typedef enum logic [2:0] {
    KIND_HBOX  = 3'd0,
    KIND_SBOX  = 3'd1,
    KIND_HSPH  = 3'd2,
    KIND_SSPH  = 3'd3,
    KIND_CYL   = 3'd4,
    KIND_CROSS = 3'd5,
    KIND_RING  = 3'd6,
    KIND_NONE  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    REG_KIND   = 3'd0,
    REG_SIZE_X = 3'd1,
    REG_SIZE_Y = 3'd2,
    REG_SIZE_Z = 3'd3,
    REG_WALL   = 3'd4,
    REG_OFFSET = 3'd5,
    REG_CENTER = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_t;

  // floor(n/3) == (n*683)>>11 for n < 768
  localparam logic [9:0] RECIP3 = 10'd683;
  localparam int RECIP3_SHIFT = 11;

  typedef struct packed {
    logic signed [16:0] wx;
    logic signed [16:0] wy;
    logic signed [16:0] wz;
    logic               lat;
  } world_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  sz;
    logic [7:0]  t;
    logic [47:0] offset;
    logic        center;
  } cfg_t;

  // after stage 1: linear terms
  typedef struct packed {
    kind_t              kind;
    logic               inr;
    logic               cov_early;
    logic               cap;
    logic signed [9:0]  a;
    logic signed [9:0]  b;
    logic signed [9:0]  c;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic signed [11:0] ez;
    logic [7:0]         sx;
    logic [7:0]         sy;
    logic [7:0]         qx;
    logic [7:0]         qy;
    logic signed [9:0]  m;
    logic [7:0]         t;
    logic [9:0]         s;
    logic [9:0]         ir;
    world_t             world;
  } lin_t;

  // after stage 2: squares
  typedef struct packed {
    kind_t       kind;
    logic        inr;
    logic        cov_early;
    logic        cap;
    logic [17:0] a2;
    logic [17:0] b2;
    logic [17:0] c2;
    logic [21:0] ex2;
    logic [21:0] ey2;
    logic [21:0] ez2;
    logic [15:0] sx2;
    logic [15:0] sy2;
    logic [15:0] qx2;
    logic [15:0] qy2;
    logic        qzero;
    logic [17:0] m2;
    logic        mpos;
    logic [17:0] t4;
    logic [19:0] s2;
    logic [19:0] ir2;
    world_t      world;
  } sq_t;

  // after stage 3: products and sums
  typedef struct packed {
    kind_t              kind;
    logic               inr;
    logic               cov_early;
    logic               cap;
    logic [33:0]        el_l;
    logic [33:0]        el_r;
    logic [31:0]        el_k;
    logic [33:0]        wl;
    logic [33:0]        wr;
    logic [31:0]        wk;
    logic               qzero;
    logic [23:0]        sum;
    logic [19:0]        s2;
    logic [19:0]        ir2;
    logic signed [21:0] l;
    logic [36:0]        rhs0;
    logic               mpos;
    world_t             world;
  } prod_t;

  // after stage 4: compares, ring square
  typedef struct packed {
    kind_t       kind;
    logic        inr;
    logic        cov_early;
    logic        cap;
    logic        ell;
    logic        wall;
    logic        outer;
    logic        inner;
    logic [41:0] l2;
    logic [38:0] rhs;
    logic        lle0;
    logic        mpos;
    world_t      world;
  } cmp_t;

  function automatic logic [17:0] sqs10(input logic signed [9:0] v);
    logic [9:0]  mg;
    logic [19:0] p;
    mg = v[9] ? 10'(-v) : 10'(v);
    p = {10'b0, mg} * {10'b0, mg};
    return p[17:0];
  endfunction

  function automatic logic [21:0] sqs12(input logic signed [11:0] v);
    logic [11:0] mg;
    logic [23:0] p;
    mg = v[11] ? 12'(-v) : 12'(v);
    p = {12'b0, mg} * {12'b0, mg};
    return p[21:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/vsc_lin.sv @@
// Stage 1: masks the cell, forms range flags, box/cross/cap tests,
// linear geometry terms and world coordinate. Depends on vsc_pkg.
`default_nettype none
module vsc_lin #(
  parameter int COORD_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ce,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_x,
  input  wire logic [7:0]    in_y,
  input  wire logic [7:0]    in_z,
  input  wire vsc_pkg::cfg_t cfg,
  output logic               out_valid,
  output vsc_pkg::lin_t      out
);

  localparam logic [7:0] CMASK = (COORD_BITS >= 8) ? 8'hFF : 8'((1 << COORD_BITS) - 1);

  logic [7:0] x, y, z, t, w, mn;
  logic [9:0] s;
  logic [18:0] dm;
  logic [7:0] d;
  logic in_box, sph_in, shell, nx, ny, nz, cap;
  logic [10:0] t6;
  logic signed [9:0] dqx, dqy;
  logic signed [11:0] di;
  logic signed [16:0] ox, oy, oz;
  vsc_pkg::lin_t nxt;

  function automatic logic near(input logic [7:0] c, input logic [7:0] sz,
                                input logic [7:0] wd);
    logic signed [8:0] df;
    logic [8:0] ab;
    df = $signed({1'b0, c}) - $signed({2'b0, sz[7:1]});
    ab = df[8] ? 9'(-df) : 9'(df);
    return ab < {1'b0, wd};
  endfunction

  function automatic logic shl(input logic [7:0] c, input logic [7:0] sz,
                               input logic [7:0] tk);
    return (c < tk) || ((9'(c) + 9'(tk)) >= 9'(sz));
  endfunction

  function automatic logic signed [11:0] ecoord(input logic [7:0] c,
                                                input logic [9:0] ss);
    logic [10:0] c6;
    c6 = 11'({c, 2'b00}) + 11'({c, 1'b0});
    return $signed({1'b0, c6}) - $signed({2'b0, ss});
  endfunction

  always_comb begin
    x = in_x & CMASK;
    y = in_y & CMASK;
    z = in_z & CMASK;
    t = cfg.t;
    w = (t == 8'd0) ? 8'd1 : t;
    s = 10'(cfg.sx) + 10'(cfg.sy) + 10'(cfg.sz);
    dm = 19'(19'(s + 10'd2) * 19'(vsc_pkg::RECIP3));
    d = dm[vsc_pkg::RECIP3_SHIFT +: 8];
    in_box = (x < cfg.sx) && (y < cfg.sy) && (z < cfg.sz);
    sph_in = (x <= d) && (y <= d) && (z <= d);
    shell = shl(x, cfg.sx, t) || shl(y, cfg.sy, t) || shl(z, cfg.sz, t);
    cap = shl(z, cfg.sz, t);
    nx = near(x, cfg.sx, w);
    ny = near(y, cfg.sy, w);
    nz = near(z, cfg.sz, w);
    t6 = 11'({t, 2'b00}) + 11'({t, 1'b0});
    dqx = $signed({2'b0, cfg.sx}) - $signed({1'b0, t, 1'b0});
    dqy = $signed({2'b0, cfg.sy}) - $signed({1'b0, t, 1'b0});
    di = $signed({2'b0, s}) - $signed({1'b0, t6});
    mn = (cfg.sx < cfg.sy) ? cfg.sx : cfg.sy;
    ox = $signed({cfg.offset[15], cfg.offset[15:0]});
    oy = $signed({cfg.offset[31], cfg.offset[31:16]});
    oz = $signed({cfg.offset[47], cfg.offset[47:32]});
    if (cfg.center) begin
      ox = ox - $signed({10'b0, cfg.sx[7:1]});
      oy = oy - $signed({10'b0, cfg.sy[7:1]});
      oz = oz - $signed({10'b0, cfg.sz[7:1]});
    end

    nxt.kind = cfg.kind;
    nxt.cap = cap;
    unique case (cfg.kind)
      vsc_pkg::KIND_HBOX: begin
        nxt.inr = in_box;
        nxt.cov_early = in_box && shell;
      end
      vsc_pkg::KIND_SBOX: begin
        nxt.inr = in_box;
        nxt.cov_early = in_box;
      end
      vsc_pkg::KIND_HSPH, vsc_pkg::KIND_SSPH: begin
        nxt.inr = sph_in;
        nxt.cov_early = 1'b0;
      end
      vsc_pkg::KIND_CROSS: begin
        nxt.inr = in_box;
        nxt.cov_early = in_box && ((ny && nz) || (nx && nz) || (nx && ny));
      end
      vsc_pkg::KIND_CYL, vsc_pkg::KIND_RING: begin
        nxt.inr = in_box;
        nxt.cov_early = 1'b0;
      end
      default: begin
        nxt.inr = 1'b0;
        nxt.cov_early = 1'b0;
      end
    endcase
    nxt.a = $signed({1'b0, x, 1'b0}) - $signed({2'b0, cfg.sx});
    nxt.b = $signed({1'b0, y, 1'b0}) - $signed({2'b0, cfg.sy});
    nxt.c = $signed({1'b0, z, 1'b0}) - $signed({2'b0, cfg.sz});
    nxt.ex = ecoord(x, s);
    nxt.ey = ecoord(y, s);
    nxt.ez = ecoord(z, s);
    nxt.sx = cfg.sx;
    nxt.sy = cfg.sy;
    nxt.qx = dqx[9] ? 8'd0 : dqx[7:0];
    nxt.qy = dqy[9] ? 8'd0 : dqy[7:0];
    nxt.m = $signed({2'b0, mn}) - $signed({1'b0, t, 1'b0});
    nxt.t = t;
    nxt.s = s;
    nxt.ir = di[11] ? 10'd0 : di[9:0];
    nxt.world.wx = ox + $signed({9'b0, x});
    nxt.world.wy = oy + $signed({9'b0, y});
    nxt.world.wz = oz + $signed({9'b0, z});
    nxt.world.lat = ~(nxt.world.wx[0] ^ nxt.world.wy[0] ^ nxt.world.wz[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/vsc_mul.sv @@
// Stages 2 and 3: squares of the linear terms, then the ellipse products,
// sphere sum and ring terms. Depends on vsc_pkg.
`default_nettype none
module vsc_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ce,
  input  wire logic          in_valid,
  input  wire vsc_pkg::lin_t in_lin,
  output logic               out_valid,
  output vsc_pkg::prod_t     out
);

  vsc_pkg::sq_t sq, sq_nxt;
  vsc_pkg::prod_t pr_nxt;
  logic sq_valid;
  logic [18:0] p;
  logic [8:0] t2;

  always_comb begin
    t2 = {in_lin.t, 1'b0};
    sq_nxt.kind = in_lin.kind;
    sq_nxt.inr = in_lin.inr;
    sq_nxt.cov_early = in_lin.cov_early;
    sq_nxt.cap = in_lin.cap;
    sq_nxt.a2 = vsc_pkg::sqs10(in_lin.a);
    sq_nxt.b2 = vsc_pkg::sqs10(in_lin.b);
    sq_nxt.c2 = vsc_pkg::sqs10(in_lin.c);
    sq_nxt.ex2 = vsc_pkg::sqs12(in_lin.ex);
    sq_nxt.ey2 = vsc_pkg::sqs12(in_lin.ey);
    sq_nxt.ez2 = vsc_pkg::sqs12(in_lin.ez);
    sq_nxt.sx2 = 16'(in_lin.sx) * 16'(in_lin.sx);
    sq_nxt.sy2 = 16'(in_lin.sy) * 16'(in_lin.sy);
    sq_nxt.qx2 = 16'(in_lin.qx) * 16'(in_lin.qx);
    sq_nxt.qy2 = 16'(in_lin.qy) * 16'(in_lin.qy);
    sq_nxt.qzero = (in_lin.qx == 8'd0) || (in_lin.qy == 8'd0);
    sq_nxt.m2 = vsc_pkg::sqs10(in_lin.m);
    sq_nxt.mpos = !in_lin.m[9] && (in_lin.m != 10'sd0);
    sq_nxt.t4 = 18'(t2) * 18'(t2);
    sq_nxt.s2 = 20'(in_lin.s) * 20'(in_lin.s);
    sq_nxt.ir2 = 20'(in_lin.ir) * 20'(in_lin.ir);
    sq_nxt.world = in_lin.world;
  end

  always_comb begin
    p = 19'(sq.a2) + 19'(sq.b2);
    pr_nxt.kind = sq.kind;
    pr_nxt.inr = sq.inr;
    pr_nxt.cov_early = sq.cov_early;
    pr_nxt.cap = sq.cap;
    pr_nxt.el_l = 34'(sq.a2) * 34'(sq.sy2);
    pr_nxt.el_r = 34'(sq.b2) * 34'(sq.sx2);
    pr_nxt.el_k = 32'(sq.sx2) * 32'(sq.sy2);
    pr_nxt.wl = 34'(sq.a2) * 34'(sq.qy2);
    pr_nxt.wr = 34'(sq.b2) * 34'(sq.qx2);
    pr_nxt.wk = 32'(sq.qx2) * 32'(sq.qy2);
    pr_nxt.qzero = sq.qzero;
    pr_nxt.sum = 24'(sq.ex2) + 24'(sq.ey2) + 24'(sq.ez2);
    pr_nxt.s2 = sq.s2;
    pr_nxt.ir2 = sq.ir2;
    pr_nxt.l = $signed({3'b0, p}) + $signed({4'b0, sq.m2}) + $signed({4'b0, sq.c2})
             - $signed({4'b0, sq.t4});
    pr_nxt.rhs0 = 37'(sq.m2) * 37'(p);
    pr_nxt.mpos = sq.mpos;
    pr_nxt.world = sq.world;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      sq_valid <= in_valid;
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq <= sq_nxt;
      out <= pr_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/vsc_cmp.sv @@
// Stages 4 and 5: magnitude compares, ring square and the final per-shape
// decision into the output register. Depends on vsc_pkg.
`default_nettype none
module vsc_cmp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ce,
  input  wire logic           in_valid,
  input  wire vsc_pkg::prod_t in_pr,
  output logic                out_valid,
  output logic [55:0]         out_data
);

  vsc_pkg::cmp_t cm, cm_nxt;
  logic cm_valid;
  logic [20:0] lmag;
  logic ring, cov, emit;
  logic [55:0] data_nxt;

  always_comb begin
    lmag = in_pr.l[21] ? 21'(-in_pr.l) : in_pr.l[20:0];
    cm_nxt.kind = in_pr.kind;
    cm_nxt.inr = in_pr.inr;
    cm_nxt.cov_early = in_pr.cov_early;
    cm_nxt.cap = in_pr.cap;
    cm_nxt.ell = (35'(in_pr.el_l) + 35'(in_pr.el_r)) <= 35'(in_pr.el_k);
    cm_nxt.wall = in_pr.qzero || ((35'(in_pr.wl) + 35'(in_pr.wr)) > 35'(in_pr.wk));
    cm_nxt.outer = in_pr.sum <= 24'(in_pr.s2);
    cm_nxt.inner = in_pr.sum <= 24'(in_pr.ir2);
    cm_nxt.l2 = 42'(lmag) * 42'(lmag);
    cm_nxt.rhs = {in_pr.rhs0, 2'b00};
    cm_nxt.lle0 = in_pr.l[21] || (in_pr.l == 22'sd0);
    cm_nxt.mpos = in_pr.mpos;
    cm_nxt.world = in_pr.world;
  end

  always_comb begin
    // sign of m picks which side of the squared compare is inside the tube
    ring = cm.mpos ? (cm.lle0 || (cm.l2 <= 42'(cm.rhs)))
                   : (cm.lle0 && (cm.l2 >= 42'(cm.rhs)));
    unique case (cm.kind)
      vsc_pkg::KIND_HSPH: cov = cm.inr && cm.outer && !cm.inner;
      vsc_pkg::KIND_SSPH: cov = cm.inr && cm.outer;
      vsc_pkg::KIND_CYL:  cov = cm.inr && cm.ell && (cm.wall || cm.cap);
      vsc_pkg::KIND_RING: cov = cm.inr && ring;
      default:            cov = cm.cov_early;
    endcase
    emit = cm.inr && cov && cm.world.lat;
    data_nxt = {1'b0, cm.world.wz, cm.world.wy, cm.world.wx,
                emit, cm.world.lat, cov, cm.inr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cm_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      cm_valid <= in_valid;
      out_valid <= cm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cm <= cm_nxt;
      out_data <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/voxel_shape_classifier.sv @@
// Five register stages, the first loaded at the input accept edge; throughput
// one item per cycle while the output is not stalled.
// The five register stages advance together whenever the output register is
// empty or being taken, so a stalled output holds every stage.
// Reset (rst, synchronous) clears all stage valid bits and loads the
// configuration defaults: hollow box, sizes 1, wall 1, offset 0, not centered.
// Top level; depends on vsc_pkg, vsc_lin, vsc_mul and vsc_cmp.
`default_nettype none
module voxel_shape_classifier #(
  parameter int COORD_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // local_x, local_y, local_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // in_scan_range, covered, lattice_ok, emit,
                                      // world_x[16:0], world_y[16:0], world_z[16:0], pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  vsc_pkg::cfg_t cfg;
  vsc_pkg::lin_t lin;
  vsc_pkg::prod_t pr;
  logic ce, lin_valid, pr_valid;

  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind <= vsc_pkg::KIND_HBOX;
      cfg.sx <= 8'd1;
      cfg.sy <= 8'd1;
      cfg.sz <= 8'd1;
      cfg.t <= 8'd1;
      cfg.offset <= 48'd0;
      cfg.center <= 1'b0;
    end else if (cfg_valid) begin
      unique case (vsc_pkg::reg_idx_t'(cfg_index))
        vsc_pkg::REG_KIND:   cfg.kind <= vsc_pkg::kind_t'(cfg_data[2:0]);
        vsc_pkg::REG_SIZE_X: cfg.sx <= cfg_data[7:0];
        vsc_pkg::REG_SIZE_Y: cfg.sy <= cfg_data[7:0];
        vsc_pkg::REG_SIZE_Z: cfg.sz <= cfg_data[7:0];
        vsc_pkg::REG_WALL:   cfg.t <= cfg_data[7:0];
        vsc_pkg::REG_OFFSET: cfg.offset <= cfg_data;
        vsc_pkg::REG_CENTER: cfg.center <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vsc_lin #(.COORD_BITS(COORD_BITS)) u_lin (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(s_tvalid && s_tready),
    .in_x(s_tdata[7:0]), .in_y(s_tdata[15:8]), .in_z(s_tdata[23:16]),
    .cfg(cfg),
    .out_valid(lin_valid), .out(lin)
  );

  vsc_mul u_mul (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(lin_valid), .in_lin(lin),
    .out_valid(pr_valid), .out(pr)
  );

  vsc_cmp u_cmp (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(pr_valid), .in_pr(pr),
    .out_valid(m_tvalid), .out_data(m_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/core/vsc_checker.sv @@
// Port-level checks of the voxel shape classifier, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module vsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        s_tready
);

  a_emit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] == (m_tdata[0] && m_tdata[1] && m_tdata[2])))
    else $error("emit disagrees with range, cover and lattice");

  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> !m_tdata[1])
    else $error("covered outside scan range");

  a_lattice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2] == !(m_tdata[4] ^ m_tdata[21] ^ m_tdata[38])))
    else $error("lattice flag disagrees with world parity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline stalled");

endmodule

bind voxel_shape_classifier vsc_checker u_vsc_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .s_tready(s_tready)
);
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for voxel_shape_classifier: directed table, then random cells
// under several sender/receiver idle mixes, checked against an in-bench predictor.
// Depends on vsc_pkg and the RTL top only.
`timescale 1ns / 1ps
module testbench;

  // field order matches m_tdata, lowest bit last
  typedef struct packed {
    logic [16:0] wz;
    logic [16:0] wy;
    logic [16:0] wx;
    logic        emit;
    logic        lat;
    logic        cov;
    logic        inr;
  } cell_res_t;

  typedef struct {
    logic [7:0] x, y, z;
    bit         known;
    cell_res_t  res;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [55:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  voxel_shape_classifier u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // shadow configuration
  vsc_pkg::kind_t sh_kind;
  logic [7:0]     sh_sx, sh_sy, sh_sz, sh_t;
  logic [47:0]    sh_off;
  logic           sh_center;

  cell_res_t pending_cells[$];
  int mismatches = 0;
  int n_sent = 0, n_checked = 0, n_emit = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 0;
  int stall_cycles = 0;

  function automatic longint sqr(longint v);
    return v * v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit ring_covers(longint a, longint b, longint c, longint m, longint t);
    longint p, l, rhs;
    p = a * a + b * b;
    l = p + m * m + c * c - 4 * t * t;
    rhs = 4 * m * m * p;
    if (m > 0) begin
      if (l <= 0) return 1;
      return l * l <= rhs;
    end
    if (l > 0) return 0;
    return l * l >= rhs;
  endfunction

  function automatic cell_res_t classify_cell(logic [7:0] lx, logic [7:0] ly,
                                              logic [7:0] lz);
    cell_res_t r;
    longint x, y, z, sx, sy, sz, t, ox, oy, oz, wx, wy, wz, s, d, sum, ir;
    longint a, b, qx, qy, w;
    bit inr, cov, inbox, outer, ell, wall, cap, nx, ny, nz;
    x = lx; y = ly; z = lz;
    sx = sh_sx; sy = sh_sy; sz = sh_sz; t = sh_t;
    ox = longint'($signed(sh_off[15:0]));
    oy = longint'($signed(sh_off[31:16]));
    oz = longint'($signed(sh_off[47:32]));
    if (sh_center) begin
      ox -= sx / 2; oy -= sy / 2; oz -= sz / 2;
    end
    wx = x + ox; wy = y + oy; wz = z + oz;
    inbox = x < sx && y < sy && z < sz;
    inr = 0; cov = 0;
    case (sh_kind)
      vsc_pkg::KIND_HBOX: begin
        inr = inbox;
        cov = inr && (x < t || x >= sx - t || y < t || y >= sy - t ||
                      z < t || z >= sz - t);
      end
      vsc_pkg::KIND_SBOX: begin
        inr = inbox; cov = inr;
      end
      vsc_pkg::KIND_HSPH, vsc_pkg::KIND_SSPH: begin
        s = sx + sy + sz;
        d = (s + 2) / 3;
        inr = x <= d && y <= d && z <= d;
        if (inr) begin
          sum = sqr(6 * x - s) + sqr(6 * y - s) + sqr(6 * z - s);
          outer = sum <= s * s;
          ir = s - 6 * t;
          if (ir < 0) ir = 0;
          cov = (sh_kind == vsc_pkg::KIND_SSPH) ? outer : (outer && !(sum <= ir * ir));
        end
      end
      vsc_pkg::KIND_CYL: begin
        inr = inbox;
        if (inr) begin
          a = 2 * x - sx; b = 2 * y - sy;
          ell = sqr(a) * sqr(sy) + sqr(b) * sqr(sx) <= sqr(sx) * sqr(sy);
          qx = sx - 2 * t; qy = sy - 2 * t;
          if (qx < 0) qx = 0;
          if (qy < 0) qy = 0;
          wall = qx == 0 || qy == 0 ||
                 sqr(a) * sqr(qy) + sqr(b) * sqr(qx) > sqr(qx) * sqr(qy);
          cap = z < t || z >= sz - t;
          cov = ell && (wall || cap);
        end
      end
      vsc_pkg::KIND_CROSS: begin
        inr = inbox;
        if (inr) begin
          w = t < 1 ? 1 : t;
          nx = abs64(x - sx / 2) < w;
          ny = abs64(y - sy / 2) < w;
          nz = abs64(z - sz / 2) < w;
          cov = (ny && nz) || (nx && nz) || (nx && ny);
        end
      end
      vsc_pkg::KIND_RING: begin
        inr = inbox;
        if (inr) cov = ring_covers(2 * x - sx, 2 * y - sy, 2 * z - sz,
                                   (sx < sy ? sx : sy) - 2 * t, t);
      end
      default: ;
    endcase
    r.inr = inr;
    r.cov = cov;
    r.lat = ((wx + wy + wz) & 1) == 0;
    r.emit = inr && cov && r.lat;
    r.wx = wx[16:0]; r.wy = wy[16:0]; r.wz = wz[16:0];
    return r;
  endfunction

  // called at negedge; leaves cfg_valid high for a following write
  task automatic write_reg(vsc_pkg::reg_idx_t idx, logic [47:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      vsc_pkg::REG_KIND:   sh_kind = vsc_pkg::kind_t'(val[2:0]);
      vsc_pkg::REG_SIZE_X: sh_sx = val[7:0];
      vsc_pkg::REG_SIZE_Y: sh_sy = val[7:0];
      vsc_pkg::REG_SIZE_Z: sh_sz = val[7:0];
      vsc_pkg::REG_WALL:   sh_t = val[7:0];
      vsc_pkg::REG_OFFSET: sh_off = val;
      vsc_pkg::REG_CENTER: sh_center = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_shape(vsc_pkg::kind_t k, logic [7:0] sx, logic [7:0] sy,
                           logic [7:0] sz, logic [7:0] t, logic [47:0] off, logic ctr);
    write_reg(vsc_pkg::REG_KIND, 48'(k));
    write_reg(vsc_pkg::REG_SIZE_X, 48'(sx));
    write_reg(vsc_pkg::REG_SIZE_Y, 48'(sy));
    write_reg(vsc_pkg::REG_SIZE_Z, 48'(sz));
    write_reg(vsc_pkg::REG_WALL, 48'(t));
    write_reg(vsc_pkg::REG_OFFSET, off);
    write_reg(vsc_pkg::REG_CENTER, 48'(ctr));
    cfg_valid <= 0;
  endtask

  // Stop sending, wait for drain, then let the pipeline settle before touching config.
  task automatic drain;
    s_tvalid <= 0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // called at negedge; item holds until accepted, tvalid stays high afterwards
  task automatic send_cell(logic [7:0] x, logic [7:0] y, logic [7:0] z, bit known,
                           cell_res_t res);
    cell_res_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    r = known ? res : classify_cell(x, y, z);
    s_tvalid <= 1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_cells.push_back(r);
    n_sent++;
    @(negedge clk);
  endtask

  // receiver ready drive
  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (recv_hold) m_tready <= 0;
    else m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    cell_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[54:0];
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_cells.pop_front();
        n_checked++;
        if (got.emit) n_emit++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp inr=%b cov=%b lat=%b emit=%b w=%0h/%0h/%0h",
                     want.inr, want.cov, want.lat, want.emit, want.wx, want.wy, want.wz);
            $display("          got inr=%b cov=%b lat=%b emit=%b w=%0h/%0h/%0h",
                     got.inr, got.cov, got.lat, got.emit, got.wx, got.wy, got.wz);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // long receiver hold-off while the sender streams with no gaps
  initial begin
    wait (n_sent > 560);
    @(negedge clk);
    recv_hold = 1;
    repeat (60) @(negedge clk);
    recv_hold = 0;
  end

  task automatic random_cell(logic [7:0] sx, logic [7:0] sy, logic [7:0] sz, bit sph);
    logic [7:0] x, y, z;
    int hi;
    cell_res_t none;
    none = '0;
    hi = (int'(sx) + int'(sy) + int'(sz) + 2) / 3 + 1;
    if ($urandom_range(9) == 0) begin
      x = 8'($urandom); y = 8'($urandom); z = 8'($urandom);
    end else if (sph) begin
      x = 8'($urandom_range(hi));
      y = 8'($urandom_range(hi));
      z = 8'($urandom_range(hi));
    end else begin
      x = 8'($urandom_range(sx));
      y = 8'($urandom_range(sy));
      z = 8'($urandom_range(sz));
    end
    send_cell(x, y, z, 1'b0, none);
  endtask

  task automatic random_phase(int n);
    vsc_pkg::kind_t k;
    logic [7:0] sx, sy, sz, t;
    logic [47:0] off;
    for (int i = 0; i < n; i += 25) begin
      k = vsc_pkg::kind_t'($urandom_range(7));
      case ($urandom_range(5))
        0: begin sx = 8'd255; sy = 8'd255; sz = 8'd255; end
        1: begin
          sx = 8'($urandom_range(2)); sy = 8'($urandom_range(2)); sz = 8'($urandom_range(2));
        end
        default: begin
          sx = 8'($urandom_range(3, 24));
          sy = 8'($urandom_range(3, 24));
          sz = 8'($urandom_range(3, 24));
        end
      endcase
      t = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      off = 48'({$urandom, $urandom});
      drain();
      set_shape(k, sx, sy, sz, t, off, 1'($urandom_range(1)));
      for (int j = 0; j < 25; j++)
        random_cell(sx, sy, sz, k == vsc_pkg::KIND_HSPH || k == vsc_pkg::KIND_SSPH);
    end
  endtask

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    cell_res_t r;
    sh_kind = vsc_pkg::KIND_HBOX; sh_sx = 8'd1; sh_sy = 8'd1; sh_sz = 8'd1; sh_t = 8'd1;
    sh_off = '0;
    sh_center = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    // after reset: 1x1x1 hollow box at origin
    r = '0; r.inr = 1; r.cov = 1; r.lat = 1; r.emit = 1;
    send_cell(8'd0, 8'd0, 8'd0, 1'b1, r);
    r = '0; r.lat = 1; r.wx = 17'd255; r.wy = 17'd255; r.wz = 17'd0;
    send_cell(8'd255, 8'd255, 8'd0, 1'b1, r);
    drain();

    // directed: every kind on a 9x7x11 shape, extreme coords and offsets
    for (int k = 0; k < 8; k++) begin
      drain();
      set_shape(vsc_pkg::kind_t'(k), 8'd9, 8'd7, 8'd11,
                (k == vsc_pkg::KIND_RING) ? 8'd2 : 8'd1,
                (k == 0) ? 48'h8000_7FFF_FFFF : 48'h0003_FFFE_0005, k[0]);
      for (int j = 0; j < 3; j++) begin
        row.x = (j == 0) ? 8'd0 : (j == 1) ? 8'd4 : 8'd255;
        row.y = (j == 1) ? 8'd3 : row.x;
        row.z = (j == 1) ? 8'd5 : row.x;
        row.known = 0;
        dir_rows.push_back(row);
      end
      foreach (dir_rows[i])
        send_cell(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, 1'b0, r);
      dir_rows.delete();
    end
    // zero size: empty scan, wide wall; world sum -257 is odd
    drain();
    write_reg(vsc_pkg::REG_NONE, 48'h123);
    set_shape(vsc_pkg::KIND_SBOX, 8'd0, 8'd255, 8'd255, 8'd255, 48'hFFFF_FFFF_FFFF, 1'b1);
    r = '0; r.wx = 17'h1FFFF; r.wy = 17'h1FF80; r.wz = 17'h1FF80;
    send_cell(8'd0, 8'd0, 8'd0, 1'b1, r);
    drain();
    set_shape(vsc_pkg::KIND_SSPH, 8'd255, 8'd255, 8'd255, 8'd255, 48'h7FFF_7FFF_7FFF, 1'b0);
    send_cell(8'd255, 8'd255, 8'd255, 1'b0, r);
    send_cell(8'd128, 8'd128, 8'd128, 1'b0, r);

    send_idle_pct = 9; recv_idle_pct = 51;
    random_phase(225);
    drain();
    send_idle_pct = 51; recv_idle_pct = 9;
    random_phase(200);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(200);

    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d cells over all shape kinds and configs; %0d checked, %0d emitted.",
             n_sent, n_checked, n_emit);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/vsc_pkg.sv
rtl/core/vsc_lin.sv
rtl/core/vsc_mul.sv
rtl/core/vsc_cmp.sv
rtl/core/voxel_shape_classifier.sv
rtl/core/vsc_checker.sv
bench/testbench.sv
